@@ rtl/estg_pkg.sv @@
// ---------------------------------------------------------------------------
// estg_pkg
// Shared types, constants and table builders for the envelope sine tone
// generator: config layout, job/result records, sine table.
// ---------------------------------------------------------------------------
package estg_pkg;

    localparam int ENV_POINTS     = 7;
    localparam int SINE_ADDR_BITS = 8;
    localparam int PHASE_BITS     = 32;
    localparam int SINE_N         = 1 << SINE_ADDR_BITS;
    localparam int QUARTER_N      = SINE_N >> 2;
    localparam int SEG_LAST       = ENV_POINTS - 2;

    localparam logic [63:0] PI_Q30   = 64'd3373259426;
    localparam int          SINE_ONE = 32768;

    // 32768 * 255, the full-scale sine times full-scale envelope
    localparam logic [24:0] MID_SCALE = 25'(SINE_ONE * 255);
    localparam logic [14:0] DAC_BASE  = 15'h7000;

    // config register indexes
    localparam logic [1:0] REG_PHASE_INC = 2'd0;
    localparam logic [1:0] REG_TIMES_LO  = 2'd1;
    localparam logic [1:0] REG_TIMES_HI  = 2'd2;
    localparam logic [1:0] REG_LEVELS    = 2'd3;

    localparam logic [31:0] RST_PHASE_INC = 32'd62008341;
    localparam logic [47:0] RST_TIMES_LO  = 48'd2405207900240;
    localparam logic [47:0] RST_TIMES_HI  = 48'd34359948085440;
    localparam logic [55:0] RST_LEVELS    = 56'd77661667328;

    // Taylor series divisors (2n)(2n+1), n = 1..8
    localparam logic [63:0] TAYLOR_DIV [8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    typedef struct packed {
        logic [31:0] phase_inc;
        logic [47:0] times_lo;
        logic [47:0] times_hi;
        logic [55:0] levels;
    } t_cfg;

    typedef struct packed {
        logic [PHASE_BITS-1:0] phase;
        logic [15:0]           cycle_time;
        logic [2:0]            seg;
        logic [15:0]           seg_start;
    } t_job;

    typedef struct packed {
        logic [7:0]  sample;
        logic [14:0] dac_word;
        logic [7:0]  env_level;
    } t_result;

    typedef logic signed [16:0] t_sine_tab [SINE_N];

    function automatic logic [15:0] f_point_time(
        input logic [47:0] lo,
        input logic [47:0] hi,
        input logic [2:0]  k
    );
        logic [15:0] t;
        case (k)
            3'd1:    t = lo[15:0];
            3'd2:    t = lo[31:16];
            3'd3:    t = lo[47:32];
            3'd4:    t = hi[15:0];
            3'd5:    t = hi[31:16];
            3'd6:    t = hi[47:32];
            default: t = 16'd0;
        endcase
        return t;
    endfunction

    function automatic logic [7:0] f_point_level(
        input logic [55:0] lv,
        input logic [2:0]  k
    );
        logic [7:0] l;
        case (k)
            3'd0:    l = lv[7:0];
            3'd1:    l = lv[15:8];
            3'd2:    l = lv[23:16];
            3'd3:    l = lv[31:24];
            3'd4:    l = lv[39:32];
            3'd5:    l = lv[47:40];
            3'd6:    l = lv[55:48];
            default: l = 8'd0;
        endcase
        return l;
    endfunction

    // Q30 Taylor series of sin, rounded to Q15; elaboration only
    function automatic logic [16:0] f_sine_quarter(input int r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      acc;
        x    = (PI_Q30 * 64'(r)) >> (SINE_ADDR_BITS - 1);
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 8; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
            if ((n % 2) == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        acc = (acc + 16384) >>> 15;
        if (acc > SINE_ONE) begin
            acc = SINE_ONE;
        end
        return 17'(acc);
    endfunction

    function automatic t_sine_tab f_build_sine();
        t_sine_tab   tab;
        int          quad;
        int          r;
        logic [16:0] v;
        for (int k = 0; k < SINE_N; k++) begin
            quad = k >> (SINE_ADDR_BITS - 2);
            r    = k & (QUARTER_N - 1);
            v    = ((quad % 2) == 1) ? f_sine_quarter(QUARTER_N - r) : f_sine_quarter(r);
            tab[k] = (quad >= 2) ? -$signed(v) : $signed(v);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = f_build_sine();

endpackage

@@ rtl/estg_front.sv @@
// ---------------------------------------------------------------------------
// estg_front
// Config registers, tick intake and sequencer state (phase, envelope
// position). Each tick snapshots the state into a two-entry job queue.
// ---------------------------------------------------------------------------
module estg_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic                i_tick,
    input  logic                i_cfg_wr_en,
    input  logic [1:0]          i_cfg_index,
    input  logic [55:0]         i_cfg_wdata,
    output estg_pkg::t_cfg      o_cfg,
    output estg_pkg::t_job      o_job,
    output logic                o_job_valid,
    input  logic                i_job_pop
);

    estg_pkg::t_cfg r_cfg;

    logic [estg_pkg::PHASE_BITS-1:0] r_phase, n_phase;
    logic [15:0]                     r_ct, n_ct;
    logic [2:0]                      r_seg, n_seg;
    logic [15:0]                     r_ss, n_ss;

    estg_pkg::t_job r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;

    logic        wr;
    logic [15:0] ct_inc;
    logic [2:0]  seg_c;
    logic [2:0]  seg_nx;
    logic [15:0] t_next;
    logic [15:0] t_end;

    assign full        = (r_cnt == 2'd2);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];
    assign o_cfg       = r_cfg;
    assign wr          = push && !full && i_tick;

    // next envelope position after one tick
    always_comb begin
        ct_inc  = r_ct + 16'd1;
        seg_c   = (r_seg > 3'(estg_pkg::SEG_LAST)) ? 3'(estg_pkg::SEG_LAST) : r_seg;
        seg_nx  = seg_c + 3'd1;
        t_next  = estg_pkg::f_point_time(r_cfg.times_lo, r_cfg.times_hi, seg_nx);
        t_end   = estg_pkg::f_point_time(r_cfg.times_lo, r_cfg.times_hi,
                                         3'(estg_pkg::ENV_POINTS - 1));
        n_phase = r_phase + r_cfg.phase_inc[estg_pkg::PHASE_BITS-1:0];
        n_ct    = ct_inc;
        n_seg   = seg_c;
        n_ss    = r_ss;
        if (ct_inc > t_next) begin
            n_ss  = t_next;
            n_seg = seg_nx;
            if (seg_nx >= 3'(estg_pkg::ENV_POINTS - 1)) begin
                n_ct  = ct_inc - t_end;
                n_seg = 3'd0;
                n_ss  = 16'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_inc <= estg_pkg::RST_PHASE_INC;
            r_cfg.times_lo  <= estg_pkg::RST_TIMES_LO;
            r_cfg.times_hi  <= estg_pkg::RST_TIMES_HI;
            r_cfg.levels    <= estg_pkg::RST_LEVELS;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                estg_pkg::REG_PHASE_INC: r_cfg.phase_inc <= i_cfg_wdata[31:0];
                estg_pkg::REG_TIMES_LO:  r_cfg.times_lo  <= i_cfg_wdata[47:0];
                estg_pkg::REG_TIMES_HI:  r_cfg.times_hi  <= i_cfg_wdata[47:0];
                estg_pkg::REG_LEVELS:    r_cfg.levels    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_ct    <= '0;
            r_seg   <= '0;
            r_ss    <= '0;
        end else if (wr) begin
            r_phase <= n_phase;
            r_ct    <= n_ct;
            r_seg   <= n_seg;
            r_ss    <= n_ss;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp].phase      <= r_phase;
            r_q[r_wp].cycle_time <= r_ct;
            r_q[r_wp].seg        <= seg_c;
            r_q[r_wp].seg_start  <= r_ss;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= ~r_wp;
            end
            if (i_job_pop) begin
                r_rp <= ~r_rp;
            end
            case ({wr, i_job_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ rtl/estg_back.sv @@
// ---------------------------------------------------------------------------
// estg_back
// Envelope interpolation (bit-serial divide), sine scaling and a
// two-entry result queue.
// ---------------------------------------------------------------------------
module estg_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  estg_pkg::t_cfg      i_cfg,
    input  estg_pkg::t_job      i_job,
    input  logic                i_job_valid,
    output logic                o_job_pop,
    output logic                empty,
    input  logic                pop,
    output logic [7:0]          o_sample,
    output logic [14:0]         o_dac_word,
    output logic [7:0]          o_env_level
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ENV  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_LVL  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_SUM  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]            r_state;
    estg_pkg::t_job        r_job;
    logic [7:0]            r_l0;
    logic                  r_up;
    logic [15:0]           r_d;
    logic [15:0]           r_rem;
    logic [7:0]            r_nlo;
    logic [7:0]            r_quo;
    logic [2:0]            r_cnt;
    logic [7:0]            r_lvl;
    logic signed [25:0]    r_prod;
    logic [15:0]           r_y;

    estg_pkg::t_result     r_rq [2];
    logic                  r_wp, r_rp;
    logic [1:0]            r_rcnt;

    logic [15:0]        t0, t1, e, d;
    logic [7:0]         l0, l1, diff;
    logic [23:0]        num;
    logic [16:0]        trial;
    logic               ge;
    logic [7:0]         sine_idx;
    logic signed [16:0] sv;
    logic signed [26:0] biased;
    logic [31:0]        scaled;
    logic [15:0]        q_sum;
    logic [7:0]         smp;
    logic               rq_wr;

    assign o_job_pop = (r_state == S_IDLE) && i_job_valid && (r_rcnt != 2'd2);
    assign rq_wr     = (r_state == S_OUT);
    assign empty     = (r_rcnt == 2'd0);
    assign o_sample    = r_rq[r_rp].sample;
    assign o_dac_word  = r_rq[r_rp].dac_word;
    assign o_env_level = r_rq[r_rp].env_level;

    always_comb begin
        t0    = estg_pkg::f_point_time(i_cfg.times_lo, i_cfg.times_hi, r_job.seg);
        t1    = estg_pkg::f_point_time(i_cfg.times_lo, i_cfg.times_hi, r_job.seg + 3'd1);
        l0    = estg_pkg::f_point_level(i_cfg.levels, r_job.seg);
        l1    = estg_pkg::f_point_level(i_cfg.levels, r_job.seg + 3'd1);
        e     = (r_job.cycle_time >= r_job.seg_start) ?
                (r_job.cycle_time - r_job.seg_start) : 16'd0;
        d     = t1 - t0;
        diff  = (l1 >= l0) ? (l1 - l0) : (l0 - l1);
        num   = 24'(diff) * 24'(e);
        trial = {r_rem, r_nlo[7]};
        ge    = (trial >= {1'b0, r_d});
        sine_idx = r_job.phase[estg_pkg::PHASE_BITS-1 -: estg_pkg::SINE_ADDR_BITS];
        sv       = estg_pkg::SINE_TAB[sine_idx];
        // 127 * (32768*255 + S*L), always non-negative
        biased = 27'(signed'({2'b00, estg_pkg::MID_SCALE})) + 27'(r_prod);
        scaled = {biased[24:0], 7'd0} - 32'(biased[24:0]);
        // floor(y / 255), exact over this range
        q_sum  = r_y + {8'd0, r_y[15:8]} + 16'd1;
        smp    = q_sum[15:8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_job_pop) begin
                        r_state <= S_ENV;
                    end
                end
                S_ENV: begin
                    if ((t1 <= t0) || (e >= d)) begin
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == 3'd7) begin
                        r_state <= S_LVL;
                    end
                end
                S_LVL:   r_state <= S_MUL;
                S_MUL:   r_state <= S_SUM;
                S_SUM:   r_state <= S_OUT;
                S_OUT:   r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_job <= i_job;
            end
            S_ENV: begin
                r_l0  <= l0;
                r_up  <= (l1 >= l0);
                r_d   <= d;
                r_rem <= num[23:8];
                r_nlo <= num[7:0];
                r_quo <= 8'd0;
                r_cnt <= 3'd0;
                if (t1 <= t0) begin
                    r_lvl <= l0;
                end else begin
                    r_lvl <= l1;
                end
            end
            S_DIV: begin
                if (ge) begin
                    r_rem <= 16'(trial - {1'b0, r_d});
                end else begin
                    r_rem <= trial[15:0];
                end
                r_nlo <= {r_nlo[6:0], 1'b0};
                r_quo <= {r_quo[6:0], ge};
                r_cnt <= r_cnt + 3'd1;
            end
            S_LVL: begin
                r_lvl <= r_up ? (r_l0 + r_quo) : (r_l0 - r_quo);
            end
            S_MUL: begin
                r_prod <= sv * $signed({1'b0, r_lvl});
            end
            S_SUM: begin
                r_y <= scaled[30:15];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rq_wr) begin
            r_rq[r_wp].sample    <= smp;
            r_rq[r_wp].dac_word  <= estg_pkg::DAC_BASE | {3'd0, smp, 4'd0};
            r_rq[r_wp].env_level <= r_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_rcnt <= 2'd0;
        end else begin
            if (rq_wr) begin
                r_wp <= ~r_wp;
            end
            if (pop && !empty) begin
                r_rp <= ~r_rp;
            end
            case ({rq_wr, pop && !empty})
                2'b10:   r_rcnt <= r_rcnt + 2'd1;
                2'b01:   r_rcnt <= r_rcnt - 2'd1;
                default: r_rcnt <= r_rcnt;
            endcase
        end
    end

endmodule

@@ rtl/envelope_sine_tone_generator_top.sv @@
// ---------------------------------------------------------------------------
// envelope_sine_tone_generator_top
// Sine oscillator shaped by a repeating seven-point linear envelope.
// ---------------------------------------------------------------------------
// The back end pops a queued tick only when idle with result queue room, then
//   runs envelope, the 8-step serial divider, level, multiply, sum and output;
//   divide and level steps are skipped when the level is a segment end point.
// Ticks queue two deep ahead of the back end; results queue two deep.
// Reset (synchronous, active low) clears phase and envelope position, loads
//   the default config and empties both queues.
module envelope_sine_tone_generator_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         push,
    output logic         full,
    input  logic         i_tick,
    output logic         empty,
    input  logic         pop,
    output logic [7:0]   o_sample,
    output logic [14:0]  o_dac_word,
    output logic [7:0]   o_env_level,
    input  logic         i_cfg_wr_en,
    input  logic [1:0]   i_cfg_index,
    input  logic [55:0]  i_cfg_wdata
);

    estg_pkg::t_cfg cfg;
    estg_pkg::t_job job;
    logic           job_valid;
    logic           job_pop;

    estg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_tick      (i_tick),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg),
        .o_job       (job),
        .o_job_valid (job_valid),
        .i_job_pop   (job_pop)
    );

    estg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job       (job),
        .i_job_valid (job_valid),
        .o_job_pop   (job_pop),
        .empty       (empty),
        .pop         (pop),
        .o_sample    (o_sample),
        .o_dac_word  (o_dac_word),
        .o_env_level (o_env_level)
    );

endmodule

@@ sim/tb_envelope_sine_tone_generator_top.sv @@
// ---------------------------------------------------------------------------
// tb_envelope_sine_tone_generator_top
// Self-checking bench for the envelope sine tone generator. Ticks go in
// through the push/full queue port and samples come out through the
// empty/pop port. A behavioral oscillator and envelope running in the bench
// predict every sample, and each popped result is checked field by field.
// Directed runs cover the reset setting, empty ticks, flat, falling and
// inverted segments, full-scale output and a long wide-span segment. Random
// runs then go through eight register settings, all but the last with random
// idling on both ports.
// ---------------------------------------------------------------------------
module tb_envelope_sine_tone_generator_top;
    timeunit 1ns;
    timeprecision 1ps;

    // longest correct stretch without a transfer is the receiver hold-off
    // plus the drain and settle pads
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_PAD      = 40;
    localparam int RANDOM_PHASES  = 8;
    localparam int TICKS_PER_SET  = 250;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        push        = 1'b0;
    logic        i_tick      = 1'b0;
    logic        pop         = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [1:0]  i_cfg_index = estg_pkg::REG_PHASE_INC;
    logic [55:0] i_cfg_wdata = '0;
    logic        full;
    logic        empty;
    logic [7:0]  o_sample;
    logic [14:0] o_dac_word;
    logic [7:0]  o_env_level;

    envelope_sine_tone_generator_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_tick      (i_tick),
        .empty       (empty),
        .pop         (pop),
        .o_sample    (o_sample),
        .o_dac_word  (o_dac_word),
        .o_env_level (o_env_level),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // oscillator shadow state
    estg_pkg::t_cfg                  shadow_cfg;
    logic [estg_pkg::PHASE_BITS-1:0] osc_phase;
    logic [15:0]                     osc_time;
    logic [15:0]                     osc_seg_start;
    logic [2:0]                      osc_seg;
    int                              sine_lut [estg_pkg::SINE_N];
    estg_pkg::t_result               pending_samples [$];

    bit gaps_on    = 1'b0;
    bit stalls_on  = 1'b0;
    bit hold_req   = 1'b0;
    int hold_left  = 0;
    int stall_left = 0;
    int idle_cycles    = 0;
    int mismatch_count = 0;

    function automatic int quarter_sine(input int unsigned r);
        bit [63:0] x;
        bit [63:0] x2;
        bit [63:0] term;
        longint    acc;
        x    = (estg_pkg::PI_Q30 * 64'(r)) >> (estg_pkg::SINE_ADDR_BITS - 1);
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 8; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
        end
        if (acc < 0) begin
            acc = 0;
        end
        acc = (acc + 16384) >>> 15;
        return (acc > estg_pkg::SINE_ONE) ? estg_pkg::SINE_ONE : int'(acc);
    endfunction

    task automatic build_sine_lut();
        int quad;
        int r;
        int v;
        for (int k = 0; k < estg_pkg::SINE_N; k++) begin
            quad = k >> (estg_pkg::SINE_ADDR_BITS - 2);
            r    = k & (estg_pkg::QUARTER_N - 1);
            v    = (quad & 1) ? quarter_sine(estg_pkg::QUARTER_N - r) : quarter_sine(r);
            sine_lut[k] = (quad & 2) ? -v : v;
        end
    endtask

    function automatic int unsigned bp_time(input int unsigned k);
        if (k == 0 || k > estg_pkg::ENV_POINTS - 1) begin
            return 0;
        end
        if (k <= 3) begin
            return int'((shadow_cfg.times_lo >> (16 * (k - 1))) & 48'hFFFF);
        end
        return int'((shadow_cfg.times_hi >> (16 * (k - 4))) & 48'hFFFF);
    endfunction

    function automatic int unsigned bp_level(input int unsigned k);
        if (k > estg_pkg::ENV_POINTS - 1) begin
            return 0;
        end
        return int'((shadow_cfg.levels >> (8 * k)) & 56'hFF);
    endfunction

    function automatic logic [7:0] envelope_level();
        int unsigned seg;
        int unsigned t0;
        int unsigned t1;
        int unsigned l0;
        int unsigned l1;
        int unsigned span;
        int unsigned elapsed;
        seg = (osc_seg > estg_pkg::SEG_LAST) ? estg_pkg::SEG_LAST : osc_seg;
        t0  = bp_time(seg);
        t1  = bp_time(seg + 1);
        l0  = bp_level(seg);
        l1  = bp_level(seg + 1);
        // time behind the segment start only after a 16-bit wrap
        elapsed = (osc_time >= osc_seg_start) ? osc_time - osc_seg_start : 0;
        if (t1 <= t0) begin
            return 8'(l0);
        end
        span = t1 - t0;
        if (elapsed >= span) begin
            return 8'(l1);
        end
        if (l1 >= l0) begin
            return 8'(l0 + (l1 - l0) * elapsed / span);
        end
        return 8'(l0 - (l0 - l1) * elapsed / span);
    endfunction

    task automatic predict_tone_sample(input logic tick_val);
        logic [7:0]        lvl;
        logic [7:0]        smp;
        int unsigned       idx;
        int unsigned       seg;
        int unsigned       nxt;
        longint            num;
        estg_pkg::t_result res;
        if (!tick_val) begin
            return;
        end
        lvl = envelope_level();
        idx = osc_phase >> (estg_pkg::PHASE_BITS - estg_pkg::SINE_ADDR_BITS);
        num = 127 * (longint'(estg_pkg::SINE_ONE) * 255 +
                     longint'(sine_lut[idx]) * longint'(lvl));
        smp = 8'(num / (longint'(estg_pkg::SINE_ONE) * 255));
        res.sample    = smp;
        res.dac_word  = estg_pkg::DAC_BASE | {3'b000, smp, 4'b0000};
        res.env_level = lvl;
        pending_samples.push_back(res);

        osc_phase = osc_phase + shadow_cfg.phase_inc[estg_pkg::PHASE_BITS-1:0];
        osc_time  = osc_time + 16'd1;
        seg = (osc_seg > estg_pkg::SEG_LAST) ? estg_pkg::SEG_LAST : osc_seg;
        nxt = bp_time(seg + 1);
        if (osc_time > nxt) begin
            osc_seg_start = 16'(nxt);
            seg++;
            if (seg >= estg_pkg::ENV_POINTS - 1) begin
                osc_time      = osc_time - 16'(bp_time(estg_pkg::ENV_POINTS - 1));
                seg           = 0;
                osc_seg_start = 16'd0;
            end
        end
        osc_seg = 3'(seg);
    endtask

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_tick(input logic tick_val);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        push   <= 1'b1;
        i_tick <= tick_val;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        predict_tone_sample(tick_val);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [55:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            estg_pkg::REG_PHASE_INC: shadow_cfg.phase_inc = data[31:0];
            estg_pkg::REG_TIMES_LO:  shadow_cfg.times_lo  = data[47:0];
            estg_pkg::REG_TIMES_HI:  shadow_cfg.times_hi  = data[47:0];
            estg_pkg::REG_LEVELS:    shadow_cfg.levels    = data;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // block idle: all samples back, then a drain pad
    task automatic settle();
        push <= 1'b0;
        while (pending_samples.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_PAD) @(negedge i_clk);
    endtask

    task automatic test_reset_defaults();
        repeat (4) send_tick(1'b1);
    endtask

    task automatic test_idle_ticks();
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
    endtask

    // flat, rising, falling and inverted segments plus the cycle wrap
    task automatic test_envelope_shapes();
        settle();
        write_reg(estg_pkg::REG_PHASE_INC, 56'h0123_4567);
        write_reg(estg_pkg::REG_TIMES_LO, {8'h00, 16'd6, 16'd6, 16'd0});
        write_reg(estg_pkg::REG_TIMES_HI, {8'h00, 16'd14, 16'd8, 16'd10});
        write_reg(estg_pkg::REG_LEVELS, 56'h01_F0_10_80_FF_00_FF);
        repeat (14) send_tick(1'b1);
    endtask

    task automatic test_output_extremes();
        logic [31:0] align;
        settle();
        write_reg(estg_pkg::REG_LEVELS, 56'hFF_FF_FF_FF_FF_FF_FF);
        // one tick that lands the phase on a quarter-turn boundary
        align = 32'd0 - {2'b00, osc_phase[29:0]};
        write_reg(estg_pkg::REG_PHASE_INC, {24'h0, align});
        send_tick(1'b1);
        settle();
        write_reg(estg_pkg::REG_PHASE_INC, 56'h4000_0000);
        repeat (4) send_tick(1'b1);
    endtask

    // park in a segment, then stretch it to a wide span and interpolate
    task automatic test_long_segment();
        int guard;
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        settle();
        write_reg(estg_pkg::REG_PHASE_INC, 56'h00F1_3579);
        write_reg(estg_pkg::REG_TIMES_LO, {8'h00, 16'd11, 16'd10, 16'd3});
        write_reg(estg_pkg::REG_TIMES_HI, {8'h00, 16'd14, 16'd13, 16'd12});
        write_reg(estg_pkg::REG_LEVELS, 56'h40_50_60_70_20_C8_0A);
        guard = 0;
        while (osc_seg != 3'd1 && guard < 200) begin
            send_tick(1'b1);
            guard++;
        end
        settle();
        write_reg(estg_pkg::REG_TIMES_LO, {8'h00, 16'hFFFF, 16'hF000, 16'd3});
        repeat (40) send_tick(1'b1);
        settle();
        write_reg(estg_pkg::REG_TIMES_LO, {8'h00, 16'd200, 16'd100, 16'd0});
        repeat (6) send_tick(1'b1);
    endtask

    task automatic test_backpressure();
        gaps_on = 1'b0;
        push   <= 1'b0;
        @(posedge i_clk);
        hold_req = 1'b1;
        @(negedge i_clk);
        repeat (24) send_tick(1'b1);
    endtask

    task automatic load_setting(input int phase_no);
        logic [47:0] times [2];
        int          t;
        if (phase_no == 0) begin
            for (int r = 0; r < 4; r++) begin
                write_reg(2'(r), {56{1'b1}});
            end
        end else if (phase_no == 1) begin
            for (int r = 0; r < 4; r++) begin
                write_reg(2'(r), 56'd0);
            end
        end else begin
            t = 0;
            for (int k = 0; k < 6; k++) begin
                if ($urandom_range(0, 31) == 0) begin
                    t = $urandom_range(0, 65535);
                end else begin
                    t = (t + $urandom_range(0, 24)) & 16'hFFFF;
                end
                times[k / 3][16 * (k % 3) +: 16] = 16'(t);
            end
            write_reg(estg_pkg::REG_PHASE_INC, 56'({$urandom, $urandom}));
            write_reg(estg_pkg::REG_TIMES_LO, {8'($urandom), times[0]});
            write_reg(estg_pkg::REG_TIMES_HI, {8'($urandom), times[1]});
            write_reg(estg_pkg::REG_LEVELS, 56'({$urandom, $urandom}));
        end
    endtask

    task automatic test_random_settings(input int first_set, input int num_sets,
                                        input bit with_idling);
        int sent;
        logic tick_val;
        for (int p = first_set; p < first_set + num_sets; p++) begin
            settle();
            load_setting(p);
            gaps_on   = with_idling;
            stalls_on = with_idling;
            sent = 0;
            while (sent < TICKS_PER_SET) begin
                tick_val = ($urandom_range(0, 9) != 0);
                send_tick(tick_val);
                if (tick_val) begin
                    sent++;
                end
            end
        end
    endtask

    // receiver: random stalls, plus the long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        estg_pkg::t_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_samples.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("unexpected sample transfer: sample %0d dac %h env %0d",
                             o_sample, o_dac_word, o_env_level);
                end
                mismatch_count++;
            end else begin
                want = pending_samples.pop_front();
                if (o_sample !== want.sample || o_dac_word !== want.dac_word ||
                    o_env_level !== want.env_level) begin
                    if (mismatch_count < 10) begin
                        $display("mismatch exp/act: sample %0d/%0d dac %h/%h env %0d/%0d",
                                 want.sample, o_sample, want.dac_word, o_dac_word,
                                 want.env_level, o_env_level);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        build_sine_lut();
        shadow_cfg.phase_inc = estg_pkg::RST_PHASE_INC;
        shadow_cfg.times_lo  = estg_pkg::RST_TIMES_LO;
        shadow_cfg.times_hi  = estg_pkg::RST_TIMES_HI;
        shadow_cfg.levels    = estg_pkg::RST_LEVELS;
        osc_phase     = '0;
        osc_time      = '0;
        osc_seg_start = '0;
        osc_seg       = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_idle_ticks();
        test_envelope_shapes();
        test_output_extremes();
        test_long_segment();
        test_random_settings(0, RANDOM_PHASES / 2, 1'b1);
        test_backpressure();
        test_random_settings(RANDOM_PHASES / 2, RANDOM_PHASES / 2 - 1, 1'b1);
        test_random_settings(RANDOM_PHASES - 1, 1, 1'b0);

        settle();
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
